// ----- rtl/bdcd_pkg.sv -----
`timescale 1ns / 1ps

package bdcd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW   = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgEnable      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounce    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClick       = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDoubleClick = 2'd3;

  localparam logic [MsW-1:0] DebounceMsRst    = 16'd10;
  localparam logic [MsW-1:0] ClickMsRst       = 16'd180;
  localparam logic [MsW-1:0] DoubleClickMsRst = 16'd200;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic             button_enable;
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   click_ms;
    logic [MsW-1:0]   double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic             prev_sample_pressed;
    logic [TimeW-1:0] last_raw_change_time;
    logic [TimeW-1:0] accepted_change_time;
    logic [TimeW-1:0] last_click_time;
    logic             stable_pressed;
    logic             click_pending_flag;
    logic             double_click_flag;
    logic             press_reported;
  } state_t;

  typedef struct packed {
    logic held_pressed;
    logic press_event;
    logic click_event;
    logic double_click_event;
    logic debounced_pressed;
  } result_t;

endpackage

// ----- rtl/bdcd_step.sv -----
`timescale 1ns / 1ps

module bdcd_step (
  input  bdcd_pkg::cfg_t                   cfg_i,
  input  bdcd_pkg::state_t                 state_i,
  input  logic [bdcd_pkg::TimeW-1:0]       now_ms_i,
  input  logic                             pin_level_i,
  output bdcd_pkg::state_t                 state_o,
  output bdcd_pkg::result_t                result_o
);
  import bdcd_pkg::*;

  logic             pressed;
  logic [TimeW-1:0] raw_diff;
  logic [TimeW-1:0] acc_diff;
  logic [TimeW-1:0] click_diff;
  logic             change;
  logic             click;
  logic             double_set;
  logic [TimeW-1:0] lc_after_click;
  logic [TimeW-1:0] click_diff_new;
  logic [TimeW-1:0] acc_diff_new;
  logic             expire;
  logic             stable_new;
  logic             dbl_flag_new;
  logic             pend_new;
  logic             held_cond;
  logic             press_ev;

  assign pressed    = ~pin_level_i;
  assign raw_diff   = now_ms_i - state_i.last_raw_change_time;
  assign acc_diff   = now_ms_i - state_i.accepted_change_time;
  assign click_diff = now_ms_i - state_i.last_click_time;

  // A level change is taken only after the pin stayed quiet long enough.
  assign change = (raw_diff > {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms}) &&
                  (state_i.stable_pressed != pressed);
  assign click  = change && !pressed &&
                  (acc_diff < {{(TimeW-MsW){1'b0}}, cfg_i.click_ms});
  assign double_set = click &&
                      (click_diff < {{(TimeW-MsW){1'b0}}, cfg_i.double_click_ms});

  assign lc_after_click = click ? now_ms_i : state_i.last_click_time;
  assign click_diff_new = click ? '0 : click_diff;
  assign acc_diff_new   = change ? '0 : acc_diff;
  assign stable_new     = change ? pressed : state_i.stable_pressed;
  assign dbl_flag_new   = state_i.double_click_flag | double_set;

  assign expire   = (lc_after_click != '0) &&
                    (click_diff_new >= {{(TimeW-MsW){1'b0}}, cfg_i.double_click_ms});
  assign pend_new = state_i.click_pending_flag | expire;

  assign held_cond = stable_new &&
                     (acc_diff_new >= {{(TimeW-MsW){1'b0}}, cfg_i.double_click_ms});
  assign press_ev  = !state_i.press_reported && held_cond;

  always_comb begin
    state_o.prev_sample_pressed  = pressed;
    state_o.last_raw_change_time = (pressed != state_i.prev_sample_pressed) ?
                                   now_ms_i : state_i.last_raw_change_time;
    state_o.accepted_change_time = change ? now_ms_i : state_i.accepted_change_time;
    state_o.stable_pressed       = stable_new;
    state_o.last_click_time      = expire ? '0 : lc_after_click;
    state_o.click_pending_flag   = pend_new;
    state_o.double_click_flag    = dbl_flag_new;
    state_o.press_reported       = 1'b0;

    result_o.held_pressed       = 1'b0;
    result_o.press_event        = 1'b0;
    result_o.click_event        = 1'b0;
    result_o.double_click_event = 1'b0;
    result_o.debounced_pressed  = stable_new;

    if (cfg_i.button_enable) begin
      // Queries run in order; each consumes what it reports.
      if (held_cond || dbl_flag_new) begin
        state_o.last_click_time = '0;
      end
      if (press_ev) begin
        state_o.press_reported = 1'b1;
      end else if (!stable_new) begin
        state_o.press_reported = 1'b0;
      end else begin
        state_o.press_reported = state_i.press_reported;
      end
      state_o.click_pending_flag  = 1'b0;
      state_o.double_click_flag   = 1'b0;
      result_o.held_pressed       = held_cond;
      result_o.press_event        = press_ev;
      result_o.click_event        = pend_new;
      result_o.double_click_event = dbl_flag_new;
    end
  end

endmodule

// ----- rtl/button_debounce_click_detector.sv -----
`timescale 1ns / 1ps
// A result is registered; it shows on the master side in the cycle after its sample.
// Throughput: one sample per clock unless the master stalls; state updates on accept.
// The output register frees itself whenever its result is taken, so a stalled master
// side holds the slave side only while the held result waits.
// Reset (rst_ni low, asynchronous) clears all detector state and restores the defaults.

module button_debounce_click_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [bdcd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bdcd_pkg::CfgDataW-1:0]      cfg_data_i,
  // Sample stream. tdata: [31:0] now_ms, [32] pin_level, [39:33] zero.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bdcd_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream. tdata: [0] held_pressed, [1] press_event, [2] click_event,
  // [3] double_click_event, [4] debounced_pressed, [7:5] zero.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bdcd_pkg::OutDataW-1:0]      m_axis_tdata
);
  import bdcd_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t result;
  logic    out_valid_q;
  logic [4:0] out_bits_q;
  logic    accept;

  // The output register can load whenever it is empty or being drained now.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_enable   <= 1'b1;
      cfg_q.debounce_ms     <= DebounceMsRst;
      cfg_q.click_ms        <= ClickMsRst;
      cfg_q.double_click_ms <= DoubleClickMsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEnable:      cfg_q.button_enable   <= cfg_data_i[0];
        CfgDebounce:    cfg_q.debounce_ms     <= cfg_data_i;
        CfgClick:       cfg_q.click_ms        <= cfg_data_i;
        CfgDoubleClick: cfg_q.double_click_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // All of the per-sample work sits in one combinational step.
  bdcd_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .now_ms_i    (s_axis_tdata[TimeW-1:0]),
    .pin_level_i (s_axis_tdata[TimeW]),
    .state_o     (state_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_bits_q <= {result.debounced_pressed, result.double_click_event,
                     result.click_event, result.press_event, result.held_pressed};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_bits_q};

endmodule
